// File: design/rpu_pkg.sv
// Shared types, codes and constants of the Rprop parameter update core.
package rpu_pkg;

  localparam int LANES_DEF  = 4;
  localparam int IN_LANES   = 4;
  localparam int VAL_W      = 32;
  localparam int STEP_W     = 31;
  localparam int ETA_W      = 16;
  localparam int ETA_FRAC   = 12;
  localparam int EPS_W      = 31;
  localparam int CNT_W      = 16;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_LOAD_GUESS = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_STEP  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD_LOWER = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOAD_UPPER = 3'd3;
  localparam logic [REQ_W-1:0] REQ_GRADIENT   = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_LOADED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_CONTINUE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_CONVERGED = 3'd2;
  localparam logic [STAT_W-1:0] ST_LIMIT     = 3'd3;
  localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_INC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_DEC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd3;

  localparam logic [ETA_W-1:0] ETA_INC_RST  = 16'd4915;
  localparam logic [ETA_W-1:0] ETA_DEC_RST  = 16'd2048;
  localparam logic [EPS_W-1:0] EPSILON_RST  = 31'd66;
  localparam logic [CNT_W-1:0] MAX_ITER_RST = 16'd1000;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] lane_value_0;
    logic signed [VAL_W-1:0] lane_value_1;
    logic signed [VAL_W-1:0] lane_value_2;
    logic signed [VAL_W-1:0] lane_value_3;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] guess_0;
    logic signed [VAL_W-1:0] guess_1;
    logic signed [VAL_W-1:0] guess_2;
    logic signed [VAL_W-1:0] guess_3;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        iteration_count;
  } out_t;

  // per-item commands from the merge stage to every lane
  typedef struct packed {
    logic ld_guess;
    logic ld_step;
    logic ld_lower;
    logic ld_upper;
    logic grad;
    logic first_pend;
  } lane_ctrl_t;

endpackage

// File: design/rpu_lane.sv
// One parameter lane: step adaptation, guess move, clamp and move check.
module rpu_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rpu_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [rpu_pkg::VAL_W-1:0]    value,
  input  logic [rpu_pkg::ETA_W-1:0]           eta_inc,
  input  logic [rpu_pkg::ETA_W-1:0]           eta_dec,
  input  logic [rpu_pkg::EPS_W-1:0]           epsilon,
  output logic signed [rpu_pkg::VAL_W-1:0]    guess_nxt,
  output logic                                small_move
);
  import rpu_pkg::*;

  // step * eta >> 12, saturated to the positive range
  function automatic logic [STEP_W-1:0] scale_step(input logic [STEP_W-1:0] step,
                                                   input logic [ETA_W-1:0]  eta);
    logic [STEP_W+ETA_W-1:0] prod;
    logic [STEP_W+ETA_W-1:0] shifted;
    prod    = step * eta;
    shifted = prod >> ETA_FRAC;
    if (|shifted[STEP_W+ETA_W-1:STEP_W]) begin
      return {STEP_W{1'b1}};
    end
    return shifted[STEP_W-1:0];
  endfunction

  logic signed [VAL_W-1:0] guess_r, lo_r, hi_r;
  logic [STEP_W-1:0]       step_r, step_inc_r, step_dec_r;
  logic                    sgn_pos_r, sgn_neg_r;

  logic                    pos, neg, flip, keep;
  logic [STEP_W-1:0]       step_new, step_nxt;
  logic signed [VAL_W:0]   guess_ext, step_ext, cand, upd, d, mag;
  logic signed [VAL_W-1:0] moved;

  always_comb begin
    pos  = ~value[VAL_W-1] & (|value);
    neg  = value[VAL_W-1];
    flip = (pos & sgn_neg_r) | (neg & sgn_pos_r);
    keep = (pos & sgn_pos_r) | (neg & sgn_neg_r);

    if (ctrl.first_pend) begin
      step_new = step_r;
    end else if (flip) begin
      step_new = step_dec_r;
    end else if (keep) begin
      step_new = step_inc_r;
    end else begin
      step_new = step_r;
    end

    guess_ext = {guess_r[VAL_W-1], guess_r};
    step_ext  = signed'({2'b00, step_new});
    if (pos) begin
      cand = guess_ext + step_ext;
    end else if (neg) begin
      cand = guess_ext - step_ext;
    end else begin
      cand = guess_ext;
    end

    // upper limit first, lower wins when the limits cross
    upd = cand;
    if (upd > $signed({hi_r[VAL_W-1], hi_r})) begin
      upd = {hi_r[VAL_W-1], hi_r};
    end
    if (upd < $signed({lo_r[VAL_W-1], lo_r})) begin
      upd = {lo_r[VAL_W-1], lo_r};
    end
    moved = upd[VAL_W-1:0];

    d          = upd - guess_ext;
    mag        = d[VAL_W] ? -d : d;
    small_move = mag[VAL_W-1:0] < {1'b0, epsilon};

    if (ctrl.ld_guess) begin
      guess_nxt = value;
    end else if (ctrl.grad) begin
      guess_nxt = moved;
    end else begin
      guess_nxt = guess_r;
    end

    if (ctrl.ld_step) begin
      step_nxt = value[STEP_W-1:0];
    end else if (ctrl.grad) begin
      step_nxt = step_new;
    end else begin
      step_nxt = step_r;
    end
  end

  // scaled copies follow step_nxt so they are ready for the very next item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guess_r    <= '0;
      step_r     <= '0;
      step_inc_r <= '0;
      step_dec_r <= '0;
      sgn_pos_r  <= 1'b0;
      sgn_neg_r  <= 1'b0;
      lo_r       <= VAL_MIN;
      hi_r       <= VAL_MAX;
    end else begin
      guess_r    <= guess_nxt;
      step_r     <= step_nxt;
      step_inc_r <= scale_step(step_nxt, eta_inc);
      step_dec_r <= scale_step(step_nxt, eta_dec);
      if (ctrl.grad) begin
        sgn_pos_r <= pos;
        sgn_neg_r <= neg;
      end
      if (ctrl.ld_lower) begin
        lo_r <= value;
      end
      if (ctrl.ld_upper) begin
        hi_r <= value;
      end
    end
  end

endmodule

// File: design/rpu_merge.sv
// Merge stage: combines lane findings, run status and iteration counter.
module rpu_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [rpu_pkg::REQ_W-1:0]     req_type,
  input  logic                          neg_any,
  input  logic                          small_all,
  input  logic [rpu_pkg::CNT_W-1:0]     max_iter,
  output rpu_pkg::lane_ctrl_t           ctrl,
  output logic [rpu_pkg::STAT_W-1:0]    status,
  output logic [rpu_pkg::CNT_W-1:0]     cnt_nxt
);
  import rpu_pkg::*;

  logic [CNT_W-1:0]  cnt_r;
  logic [STAT_W-1:0] run_r, run_nxt;
  logic              first_r, first_nxt;
  logic              steps_ok_r, steps_ok_nxt;
  logic              load_ok;

  always_comb begin
    ctrl            = '0;
    ctrl.first_pend = first_r;
    status          = ST_REJECTED;
    cnt_nxt         = cnt_r;
    run_nxt         = run_r;
    first_nxt       = first_r;
    steps_ok_nxt    = steps_ok_r;
    load_ok         = 1'b0;

    if (fire) begin
      unique case (req_type) inside
        REQ_LOAD_GUESS, REQ_LOAD_STEP, REQ_LOAD_LOWER, REQ_LOAD_UPPER: begin
          load_ok = !((req_type == REQ_LOAD_STEP) && neg_any);
          if (!load_ok) begin
            steps_ok_nxt = 1'b0;
          end else begin
            ctrl.ld_guess = (req_type == REQ_LOAD_GUESS);
            ctrl.ld_step  = (req_type == REQ_LOAD_STEP);
            ctrl.ld_lower = (req_type == REQ_LOAD_LOWER);
            ctrl.ld_upper = (req_type == REQ_LOAD_UPPER);
            if (req_type == REQ_LOAD_STEP) begin
              steps_ok_nxt = 1'b1;
            end
            first_nxt = 1'b1;
            cnt_nxt   = '0;
            run_nxt   = ST_LOADED;
            status    = ST_LOADED;
          end
        end
        REQ_GRADIENT: begin
          if (!steps_ok_r) begin
            status = ST_REJECTED;
          end else if (run_r == ST_CONVERGED || run_r == ST_LIMIT) begin
            status = run_r;
          end else begin
            ctrl.grad = 1'b1;
            first_nxt = 1'b0;
            if (small_all) begin
              run_nxt = ST_CONVERGED;
            end else if (cnt_r > max_iter) begin
              run_nxt = ST_LIMIT;
            end else begin
              if (cnt_r != {CNT_W{1'b1}}) begin
                cnt_nxt = cnt_r + 1'b1;
              end
              run_nxt = ST_CONTINUE;
            end
            status = run_nxt;
          end
        end
        default: begin
          status = ST_REJECTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      run_r      <= ST_LOADED;
      first_r    <= 1'b1;
      steps_ok_r <= 1'b1;
    end else begin
      cnt_r      <= cnt_nxt;
      run_r      <= run_nxt;
      first_r    <= first_nxt;
      steps_ok_r <= steps_ok_nxt;
    end
  end

endmodule

// File: design/rprop_parameter_update_core.sv
// Top level of the Rprop parameter update core: lanes, merge stage, output queue.
// A result is at out_data in the cycle after its transfer when no older result stays queued.
// Throughput: one item per cycle while in_ready is high; the lanes update guesses and steps,
// which the next item reads, and the scaled steps are registered one item ahead.
// A two-entry output queue holds results while out_ready is low; in_ready drops when full.
// Reset (synchronous, rst_n low) restores all registers but the queue entries and empties the queue.
module rprop_parameter_update_core #(
  parameter int LANES = rpu_pkg::LANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rpu_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rpu_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [rpu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpu_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rpu_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers. The lanes see the next eta values so that
  // their pre-scaled steps always match the live eta factors.
  // ---------------------------------------------------------------
  logic [ETA_W-1:0] eta_inc_r, eta_inc_nxt;
  logic [ETA_W-1:0] eta_dec_r, eta_dec_nxt;
  logic [EPS_W-1:0] eps_r, eps_nxt;
  logic [CNT_W-1:0] max_iter_r, max_iter_nxt;

  always_comb begin
    eta_inc_nxt  = eta_inc_r;
    eta_dec_nxt  = eta_dec_r;
    eps_nxt      = eps_r;
    max_iter_nxt = max_iter_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ETA_INC:  eta_inc_nxt  = cfg_wdata[ETA_W-1:0];
        CFG_ETA_DEC:  eta_dec_nxt  = cfg_wdata[ETA_W-1:0];
        CFG_EPSILON:  eps_nxt      = cfg_wdata[EPS_W-1:0];
        CFG_MAX_ITER: max_iter_nxt = cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_inc_r  <= ETA_INC_RST;
      eta_dec_r  <= ETA_DEC_RST;
      eps_r      <= EPSILON_RST;
      max_iter_r <= MAX_ITER_RST;
    end else begin
      eta_inc_r  <= eta_inc_nxt;
      eta_dec_r  <= eta_dec_nxt;
      eps_r      <= eps_nxt;
      max_iter_r <= max_iter_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Input transfer and lane fan-out. Lanes past the four input
  // fields always see zero.
  // ---------------------------------------------------------------
  logic                    in_fire;
  logic signed [VAL_W-1:0] in_val    [IN_LANES];
  logic signed [VAL_W-1:0] lane_val  [LANES];
  logic signed [VAL_W-1:0] lane_guess[LANES];
  logic [LANES-1:0]        lane_neg, lane_small;
  lane_ctrl_t              ctrl;
  logic [STAT_W-1:0]       res_status;
  logic [CNT_W-1:0]        res_count;

  assign in_fire   = in_valid && in_ready;
  assign in_val[0] = in_data.lane_value_0;
  assign in_val[1] = in_data.lane_value_1;
  assign in_val[2] = in_data.lane_value_2;
  assign in_val[3] = in_data.lane_value_3;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < IN_LANES) begin : g_fed
      assign lane_val[i] = in_val[i];
    end else begin : g_zero
      assign lane_val[i] = '0;
    end
    assign lane_neg[i] = lane_val[i][VAL_W-1];

    rpu_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .value      (lane_val[i]),
      .eta_inc    (eta_inc_nxt),
      .eta_dec    (eta_dec_nxt),
      .epsilon    (eps_r),
      .guess_nxt  (lane_guess[i]),
      .small_move (lane_small[i])
    );
  end

  // converged when every lane moved less than epsilon (same as the largest move)
  rpu_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .req_type  (in_data.req_type),
    .neg_any   (|lane_neg),
    .small_all (&lane_small),
    .max_iter  (max_iter_r),
    .ctrl      (ctrl),
    .status    (res_status),
    .cnt_nxt   (res_count)
  );

  // ---------------------------------------------------------------
  // Result assembly: guesses beyond LANES read as zero.
  // ---------------------------------------------------------------
  logic signed [VAL_W-1:0] res_guess[IN_LANES];
  out_t                    res;

  for (genvar j = 0; j < IN_LANES; j++) begin : g_res
    if (j < LANES) begin : g_live
      assign res_guess[j] = lane_guess[j];
    end else begin : g_none
      assign res_guess[j] = '0;
    end
  end

  always_comb begin
    res.guess_0         = res_guess[0];
    res.guess_1         = res_guess[1];
    res.guess_2         = res_guess[2];
    res.guess_3         = res_guess[3];
    res.status          = res_status;
    res.iteration_count = res_count;
  end

  // ---------------------------------------------------------------
  // Two-entry output queue, head in slot 0. in_ready depends only on
  // the registered fill level.
  // ---------------------------------------------------------------
  out_t       q_r [2];
  logic [1:0] fill_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fill_r != 2'd0);
  assign in_ready  = (fill_r != 2'd2);
  assign out_data  = q_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_r + {1'b0, in_fire} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if ((in_fire && fill_r == 2'd0) || (in_fire && pop && fill_r == 2'd1)) begin
      q_r[0] <= res;
    end else if (pop && fill_r == 2'd2) begin
      q_r[0] <= q_r[1];
    end
    if (in_fire && ((fill_r == 2'd1 && !pop) || (fill_r == 2'd2 && pop))) begin
      q_r[1] <= res;
    end
  end

endmodule

// File: design/rpu_checker.sv
// Port-level checks for the Rprop parameter update core, bound to the top level.
module rpu_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input rpu_pkg::in_t  in_data,
  input logic          out_valid,
  input rpu_pkg::out_t out_data
);
  import rpu_pkg::*;

  logic take_empty;
  assign take_empty = in_valid && in_ready && !out_valid;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output queue");

  a_guess_load: assert property (@(posedge clk) disable iff (!rst_n)
    take_empty && in_data.req_type == REQ_LOAD_GUESS |=>
      out_valid && out_data.status == ST_LOADED && out_data.iteration_count == '0 &&
      out_data.guess_0 == $past(in_data.lane_value_0))
    else $error("guess load not reflected in result");

  a_bad_request: assert property (@(posedge clk) disable iff (!rst_n)
    take_empty && in_data.req_type > REQ_GRADIENT |=>
      out_valid && out_data.status == ST_REJECTED)
    else $error("unused request code not rejected");

endmodule

bind rprop_parameter_update_core rpu_checker u_rpu_checker (.*);
